### sv/gmdt_pkg.sv
// ----------------------------------------------------------------------------
// gmdt_pkg: shared types and constants for the grid maze DFS tracer
// Cell indexing, op codes, register indexes, label layout and FSM states.
// ----------------------------------------------------------------------------
package gmdt_pkg;

  // Grid geometry
  localparam int MAX_SIDE = 16;
  localparam int SIDE_W   = $clog2(MAX_SIDE);
  localparam int CELLS    = MAX_SIDE * MAX_SIDE;
  localparam int CELL_W   = 2 * SIDE_W;
  localparam int COUNT_W  = SIDE_W + 1;

  // Stack pointer counts up to CELLS inclusive
  localparam int SP_W     = CELL_W + 1;
  localparam int DEPTH_W  = 9;
  localparam int DIR_W    = 3;

  // Label word: dead-end flag over path depth
  localparam int LABEL_W  = DEPTH_W + 1;
  localparam int DEAD_BIT = DEPTH_W;

  // Stack word: direction over cell
  localparam int STACK_W  = CELL_W + DIR_W;

  // Wall code bits
  localparam int WALL_W     = 2;
  localparam int WALL_EAST  = 0;
  localparam int WALL_SOUTH = 1;

  // Register file widths and indexes
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = COUNT_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ROW_COUNT = 3'd0,
    REG_COL_COUNT = 3'd1,
    REG_START_ROW = 3'd2,
    REG_START_COL = 3'd3,
    REG_GOAL_ROW  = 3'd4,
    REG_GOAL_COL  = 3'd5
  } reg_idx_t;

  // Input op codes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SOLVE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Cell mark codes returned by a read
  localparam logic [1:0] MARK_NONE = 2'd0;
  localparam logic [1:0] MARK_PATH = 2'd1;
  localparam logic [1:0] MARK_DEAD = 2'd2;

  // Neighbour order; DIR_DONE means all four have been tried
  localparam logic [DIR_W-1:0] DIR_WEST  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_NORTH = 3'd1;
  localparam logic [DIR_W-1:0] DIR_EAST  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_SOUTH = 3'd3;
  localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

  // Stream widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // Controller states
  typedef enum logic [7:0] {
    ST_INIT  = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_READ  = 8'b0000_0100,
    ST_CLEAR = 8'b0000_1000,
    ST_START = 8'b0001_0000,
    ST_CHECK = 8'b0010_0000,
    ST_EVAL  = 8'b0100_0000,
    ST_POP   = 8'b1000_0000
  } state_t;

  // Out-of-range counts: zero reads as one, above MAX_SIDE as MAX_SIDE
  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = COUNT_W'(1);
    end else if (v > COUNT_W'(MAX_SIDE)) begin
      res = COUNT_W'(MAX_SIDE);
    end
    return res;
  endfunction

endpackage

### sv/grid_maze_dfs_tracer.sv
// ----------------------------------------------------------------------------
// grid_maze_dfs_tracer: depth-first maze solver over on-chip cell memories
// Loads per-cell wall codes, solves from start to goal with an explicit
// stack, and reads back per-cell labels (path depth or dead end).
// ----------------------------------------------------------------------------
// After reset the block clears its wall and label memories and takes no
// item during that time. A load, or an unused op, is answered from the
// idle state; a read makes one label memory access (ST_READ). A solve
// first clears the label memory, then walks the maze: each neighbour
// test reads the wall and label memories in ST_CHECK and evaluates in
// ST_EVAL, a neighbour outside the grid is skipped in ST_CHECK alone, and
// each backtrack restores the top from the stack memory in ST_POP. Items
// are handled one at a time; the result register lets the next item be
// accepted as soon as the previous result is taken or in the same cycle.
module grid_maze_dfs_tracer (
  input  logic                            clk,
  input  logic                            rst_n,
  // config write port
  input  logic                            cfg_we,
  input  logic [gmdt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [gmdt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // op[1:0], cell_row[5:2], cell_col[9:6], wall_code[11:10], zero pad
  input  logic [gmdt_pkg::IN_DATA_W-1:0]  in_tdata,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // goal_reached[0], cell_mark[2:1], path_depth[11:3], zero pad
  output logic [gmdt_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int CELL_W  = gmdt_pkg::CELL_W;
  localparam int SIDE_W  = gmdt_pkg::SIDE_W;
  localparam int COUNT_W = gmdt_pkg::COUNT_W;
  localparam int SP_W    = gmdt_pkg::SP_W;
  localparam int DEPTH_W = gmdt_pkg::DEPTH_W;
  localparam int DIR_W   = gmdt_pkg::DIR_W;
  localparam int LABEL_W = gmdt_pkg::LABEL_W;
  localparam int STACK_W = gmdt_pkg::STACK_W;
  localparam int WALL_W  = gmdt_pkg::WALL_W;
  localparam int CELLS   = gmdt_pkg::CELLS;

  // Input field split
  logic [1:0]        in_op;
  logic [SIDE_W-1:0] in_row;
  logic [SIDE_W-1:0] in_col;
  logic [WALL_W-1:0] in_wall;
  logic              in_xfer;

  assign in_op   = in_tdata[1:0];
  assign in_row  = in_tdata[5:2];
  assign in_col  = in_tdata[9:6];
  assign in_wall = in_tdata[11:10];

  // Config registers
  logic [COUNT_W-1:0] row_count_r, col_count_r;
  logic [SIDE_W-1:0]  start_row_r, start_col_r, goal_row_r, goal_col_r;

  // Control state
  gmdt_pkg::state_t   state_r, state_nxt;
  logic [CELL_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [SP_W-1:0]    sp_r, sp_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Search payload
  logic [CELL_W-1:0]  top_cell_r, top_cell_nxt;
  logic [DIR_W-1:0]   top_dir_r, top_dir_nxt;
  logic [CELL_W-1:0]  nb_cell_r, nb_cell_nxt;
  logic               wall_sel_r, wall_sel_nxt;

  // Result payload
  logic               out_goal_r, out_goal_nxt;
  logic [1:0]         out_mark_r, out_mark_nxt;
  logic [DEPTH_W-1:0] out_depth_r, out_depth_nxt;

  // Memories and their ports
  logic [WALL_W-1:0]  wall_mem [CELLS];
  logic [LABEL_W-1:0] label_mem [CELLS];
  logic [STACK_W-1:0] stack_mem [CELLS];

  logic               wall_we;
  logic [CELL_W-1:0]  wall_waddr, wall_raddr;
  logic [WALL_W-1:0]  wall_wdata, wall_rdata_r;

  logic               label_we;
  logic [CELL_W-1:0]  label_waddr, label_raddr;
  logic [LABEL_W-1:0] label_wdata, label_rdata_r;

  logic               stack_we;
  logic [CELL_W-1:0]  stack_waddr, stack_raddr;
  logic [STACK_W-1:0] stack_wdata, stack_rdata_r;

  // Derived geometry
  logic [COUNT_W-1:0] rows_eff, cols_eff;
  logic [CELL_W-1:0]  start_cell, goal_cell;
  logic               start_ok, goal_ok;
  logic [SIDE_W-1:0]  top_row, top_col;
  logic [SP_W-1:0]    sp_dec1, sp_dec2, sp_inc1;

  assign rows_eff   = gmdt_pkg::clamp_count(row_count_r);
  assign cols_eff   = gmdt_pkg::clamp_count(col_count_r);
  assign start_cell = {start_row_r, start_col_r};
  assign goal_cell  = {goal_row_r, goal_col_r};
  assign start_ok   = ({1'b0, start_row_r} < rows_eff) && ({1'b0, start_col_r} < cols_eff);
  assign goal_ok    = ({1'b0, goal_row_r} < rows_eff) && ({1'b0, goal_col_r} < cols_eff);
  assign top_row    = top_cell_r[CELL_W-1:SIDE_W];
  assign top_col    = top_cell_r[SIDE_W-1:0];
  assign sp_dec1    = sp_r - SP_W'(1);
  assign sp_dec2    = sp_r - SP_W'(2);
  assign sp_inc1    = sp_r + SP_W'(1);

  // Handshake
  assign in_tready  = (state_r == gmdt_pkg::ST_IDLE) && (!out_valid_r || out_tready);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(gmdt_pkg::OUT_DATA_W - 3 - DEPTH_W){1'b0}},
                       out_depth_r, out_mark_r, out_goal_r};

  // Next-state and memory control
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    sp_nxt        = sp_r;
    top_cell_nxt  = top_cell_r;
    top_dir_nxt   = top_dir_r;
    nb_cell_nxt   = nb_cell_r;
    wall_sel_nxt  = wall_sel_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_goal_nxt  = out_goal_r;
    out_mark_nxt  = out_mark_r;
    out_depth_nxt = out_depth_r;

    wall_we     = 1'b0;
    wall_waddr  = clr_addr_r;
    wall_wdata  = '0;
    wall_raddr  = top_cell_r;
    label_we    = 1'b0;
    label_waddr = clr_addr_r;
    label_wdata = '0;
    label_raddr = top_cell_r;
    stack_we    = 1'b0;
    stack_waddr = sp_dec1[CELL_W-1:0];
    stack_wdata = {top_dir_r, top_cell_r};
    stack_raddr = sp_dec2[CELL_W-1:0];

    case (state_r)
      // clear walls and labels after reset
      gmdt_pkg::ST_INIT: begin
        wall_we      = 1'b1;
        label_we     = 1'b1;
        clr_addr_nxt = clr_addr_r + CELL_W'(1);
        if (clr_addr_r == CELL_W'(CELLS - 1)) begin
          state_nxt = gmdt_pkg::ST_IDLE;
        end
      end

      gmdt_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (in_op)
            gmdt_pkg::OP_LOAD: begin
              wall_we       = 1'b1;
              wall_waddr    = {in_row, in_col};
              wall_wdata    = in_wall;
              out_valid_nxt = 1'b1;
              out_goal_nxt  = 1'b0;
              out_mark_nxt  = gmdt_pkg::MARK_NONE;
              out_depth_nxt = '0;
            end
            gmdt_pkg::OP_SOLVE: begin
              clr_addr_nxt = '0;
              state_nxt    = gmdt_pkg::ST_CLEAR;
            end
            gmdt_pkg::OP_READ: begin
              label_raddr = {in_row, in_col};
              state_nxt   = gmdt_pkg::ST_READ;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_goal_nxt  = 1'b0;
              out_mark_nxt  = gmdt_pkg::MARK_NONE;
              out_depth_nxt = '0;
            end
          endcase
        end
      end

      // decode the registered label word from the read issued in idle
      gmdt_pkg::ST_READ: begin
        out_valid_nxt = 1'b1;
        out_goal_nxt  = 1'b0;
        if (label_rdata_r[gmdt_pkg::DEAD_BIT]) begin
          out_mark_nxt  = gmdt_pkg::MARK_DEAD;
          out_depth_nxt = '0;
        end else if (label_rdata_r != '0) begin
          out_mark_nxt  = gmdt_pkg::MARK_PATH;
          out_depth_nxt = label_rdata_r[DEPTH_W-1:0];
        end else begin
          out_mark_nxt  = gmdt_pkg::MARK_NONE;
          out_depth_nxt = '0;
        end
        state_nxt = gmdt_pkg::ST_IDLE;
      end

      // sweep the label memory before a solve
      gmdt_pkg::ST_CLEAR: begin
        label_we     = 1'b1;
        clr_addr_nxt = clr_addr_r + CELL_W'(1);
        if (clr_addr_r == CELL_W'(CELLS - 1)) begin
          state_nxt = gmdt_pkg::ST_START;
        end
      end

      // seed the stack with the start cell; end early if start is out or is goal
      gmdt_pkg::ST_START: begin
        sp_nxt = '0;
        if (!start_ok) begin
          out_valid_nxt = 1'b1;
          out_goal_nxt  = 1'b0;
          out_mark_nxt  = gmdt_pkg::MARK_NONE;
          out_depth_nxt = '0;
          state_nxt     = gmdt_pkg::ST_IDLE;
        end else begin
          top_cell_nxt = start_cell;
          top_dir_nxt  = gmdt_pkg::DIR_WEST;
          sp_nxt       = SP_W'(1);
          label_we     = 1'b1;
          label_waddr  = start_cell;
          label_wdata  = LABEL_W'(1);
          if (goal_ok && start_cell == goal_cell) begin
            out_valid_nxt = 1'b1;
            out_goal_nxt  = 1'b1;
            out_mark_nxt  = gmdt_pkg::MARK_NONE;
            out_depth_nxt = '0;
            state_nxt     = gmdt_pkg::ST_IDLE;
          end else begin
            state_nxt = gmdt_pkg::ST_CHECK;
          end
        end
      end

      // pick the next direction, or backtrack when all are tried
      gmdt_pkg::ST_CHECK: begin
        if (top_dir_r >= gmdt_pkg::DIR_DONE) begin
          label_we    = 1'b1;
          label_waddr = top_cell_r;
          label_wdata = LABEL_W'(1) << gmdt_pkg::DEAD_BIT;
          sp_nxt      = sp_dec1;
          if (sp_r == SP_W'(1)) begin
            out_valid_nxt = 1'b1;
            out_goal_nxt  = 1'b0;
            out_mark_nxt  = gmdt_pkg::MARK_NONE;
            out_depth_nxt = '0;
            state_nxt     = gmdt_pkg::ST_IDLE;
          end else begin
            state_nxt = gmdt_pkg::ST_POP;
          end
        end else begin
          top_dir_nxt = top_dir_r + DIR_W'(1);
          case (top_dir_r)
            gmdt_pkg::DIR_WEST: begin
              nb_cell_nxt  = top_cell_r - CELL_W'(1);
              wall_raddr   = top_cell_r - CELL_W'(1);
              wall_sel_nxt = 1'b0;
              if (top_col != '0) begin
                state_nxt = gmdt_pkg::ST_EVAL;
              end
            end
            gmdt_pkg::DIR_NORTH: begin
              nb_cell_nxt  = top_cell_r - CELL_W'(gmdt_pkg::MAX_SIDE);
              wall_raddr   = top_cell_r - CELL_W'(gmdt_pkg::MAX_SIDE);
              wall_sel_nxt = 1'b1;
              if (top_row != '0) begin
                state_nxt = gmdt_pkg::ST_EVAL;
              end
            end
            gmdt_pkg::DIR_EAST: begin
              nb_cell_nxt  = top_cell_r + CELL_W'(1);
              wall_raddr   = top_cell_r;
              wall_sel_nxt = 1'b0;
              if (({1'b0, top_col} + COUNT_W'(1)) < cols_eff) begin
                state_nxt = gmdt_pkg::ST_EVAL;
              end
            end
            default: begin
              nb_cell_nxt  = top_cell_r + CELL_W'(gmdt_pkg::MAX_SIDE);
              wall_raddr   = top_cell_r;
              wall_sel_nxt = 1'b1;
              if (({1'b0, top_row} + COUNT_W'(1)) < rows_eff) begin
                state_nxt = gmdt_pkg::ST_EVAL;
              end
            end
          endcase
          label_raddr = nb_cell_nxt;
        end
      end

      // wall and neighbour label are in; push if open and unvisited
      gmdt_pkg::ST_EVAL: begin
        state_nxt = gmdt_pkg::ST_CHECK;
        if (!(wall_sel_r ? wall_rdata_r[gmdt_pkg::WALL_SOUTH]
                         : wall_rdata_r[gmdt_pkg::WALL_EAST])
            && label_rdata_r == '0 && sp_r < SP_W'(CELLS)) begin
          stack_we     = 1'b1;
          label_we     = 1'b1;
          label_waddr  = nb_cell_r;
          label_wdata  = {1'b0, sp_inc1[DEPTH_W-1:0]};
          sp_nxt       = sp_inc1;
          top_cell_nxt = nb_cell_r;
          top_dir_nxt  = gmdt_pkg::DIR_WEST;
          if (goal_ok && nb_cell_r == goal_cell) begin
            out_valid_nxt = 1'b1;
            out_goal_nxt  = 1'b1;
            out_mark_nxt  = gmdt_pkg::MARK_NONE;
            out_depth_nxt = '0;
            state_nxt     = gmdt_pkg::ST_IDLE;
          end
        end
      end

      // restore the new top of stack from memory
      gmdt_pkg::ST_POP: begin
        top_cell_nxt = stack_rdata_r[CELL_W-1:0];
        top_dir_nxt  = stack_rdata_r[STACK_W-1:CELL_W];
        state_nxt    = gmdt_pkg::ST_CHECK;
      end

      default: begin
        state_nxt = gmdt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers and config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gmdt_pkg::ST_INIT;
      clr_addr_r  <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
      row_count_r <= COUNT_W'(1);
      col_count_r <= COUNT_W'(1);
      start_row_r <= '0;
      start_col_r <= '0;
      goal_row_r  <= '0;
      goal_col_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          gmdt_pkg::REG_ROW_COUNT: row_count_r <= cfg_wdata;
          gmdt_pkg::REG_COL_COUNT: col_count_r <= cfg_wdata;
          gmdt_pkg::REG_START_ROW: start_row_r <= cfg_wdata[SIDE_W-1:0];
          gmdt_pkg::REG_START_COL: start_col_r <= cfg_wdata[SIDE_W-1:0];
          gmdt_pkg::REG_GOAL_ROW:  goal_row_r  <= cfg_wdata[SIDE_W-1:0];
          gmdt_pkg::REG_GOAL_COL:  goal_col_r  <= cfg_wdata[SIDE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top_cell_r  <= top_cell_nxt;
    top_dir_r   <= top_dir_nxt;
    nb_cell_r   <= nb_cell_nxt;
    wall_sel_r  <= wall_sel_nxt;
    out_goal_r  <= out_goal_nxt;
    out_mark_r  <= out_mark_nxt;
    out_depth_r <= out_depth_nxt;
  end

  // Wall memory
  always_ff @(posedge clk) begin
    if (wall_we) begin
      wall_mem[wall_waddr] <= wall_wdata;
    end
    wall_rdata_r <= wall_mem[wall_raddr];
  end

  // Label memory
  always_ff @(posedge clk) begin
    if (label_we) begin
      label_mem[label_waddr] <= label_wdata;
    end
    label_rdata_r <= label_mem[label_raddr];
  end

  // Stack memory, holds every entry below the top of stack
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    stack_rdata_r <= stack_mem[stack_raddr];
  end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the grid maze DFS tracer
// Loads wall codes and runs solves and label reads over the item stream. A
// local copy of the maze, the labels and the search predicts every result.
// Directed corner cases come first: clamped counts, start or goal outside
// the used area, and a full 16x16 serpentine that takes the deepest path.
// Random mazes follow. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_SPARE = 2'd3;   // unused op code, no effect

  // Wall codes
  localparam logic [1:0] CODE_OPEN  = 2'd0;
  localparam logic [1:0] CODE_EAST  = 2'd1;
  localparam logic [1:0] CODE_SOUTH = 2'd2;
  localparam logic [1:0] CODE_BOTH  = 2'd3;

  // Receiver stall patterns
  localparam int RX_FREE   = 0;
  localparam int RX_JITTER = 1;
  localparam int RX_SLOW   = 2;
  localparam int RX_LIGHT  = 3;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEM_TARGET = 550;

  // --------------------------------------------------------------------------
  // Maze tracker: mirrors walls, labels and registers, queues expected results
  // --------------------------------------------------------------------------
  class maze_scoreboard;
    typedef struct {
      bit                         goal_hit;
      bit [1:0]                   mark;
      bit [gmdt_pkg::DEPTH_W-1:0] depth;
    } cell_report_t;

    cell_report_t                  pending_reports[$];
    int                            fail_count;
    int                            result_count;
    bit [1:0]                      walls [gmdt_pkg::CELLS];
    bit [gmdt_pkg::LABEL_W-1:0]    labels [gmdt_pkg::CELLS];
    int                            stack_pos [gmdt_pkg::CELLS];
    int                            stack_dir [gmdt_pkg::CELLS];
    bit [gmdt_pkg::CFG_DATA_W-1:0] row_count, col_count;
    bit [3:0]                      start_row, start_col, goal_row, goal_col;

    function new();
      fail_count   = 0;
      result_count = 0;
      row_count    = 1;
      col_count    = 1;
      start_row    = 0;
      start_col    = 0;
      goal_row     = 0;
      goal_col     = 0;
      foreach (walls[i]) walls[i] = CODE_OPEN;
      foreach (labels[i]) labels[i] = '0;
    endfunction

    // zero counts as one, anything above the grid as the full side
    function int effective_side(bit [gmdt_pkg::CFG_DATA_W-1:0] v);
      if (v == 0) return 1;
      if (v > gmdt_pkg::MAX_SIDE) return gmdt_pkg::MAX_SIDE;
      return int'(v);
    endfunction

    function void set_reg(gmdt_pkg::reg_idx_t idx, bit [gmdt_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        gmdt_pkg::REG_ROW_COUNT: row_count = v;
        gmdt_pkg::REG_COL_COUNT: col_count = v;
        gmdt_pkg::REG_START_ROW: start_row = v[3:0];
        gmdt_pkg::REG_START_COL: start_col = v[3:0];
        gmdt_pkg::REG_GOAL_ROW:  goal_row  = v[3:0];
        gmdt_pkg::REG_GOAL_COL:  goal_col  = v[3:0];
        default: ;
      endcase
    endfunction

    // Depth-first walk, west/north/east/south, stops on entering the goal
    function bit trace_maze();
      int rows, cols, goal, sp, tos, here, r, c, d, nbr;
      bit passable;
      rows = effective_side(row_count);
      cols = effective_side(col_count);
      foreach (labels[i]) labels[i] = '0;
      if (start_row >= rows || start_col >= cols) return 1'b0;
      if (goal_row < rows && goal_col < cols) goal = goal_row * gmdt_pkg::MAX_SIDE + goal_col;
      else goal = gmdt_pkg::CELLS;
      stack_pos[0] = start_row * gmdt_pkg::MAX_SIDE + start_col;
      stack_dir[0] = int'(gmdt_pkg::DIR_WEST);
      sp = 1;
      labels[stack_pos[0]] = gmdt_pkg::LABEL_W'(1);
      if (stack_pos[0] == goal) return 1'b1;
      while (sp > 0) begin
        tos = sp - 1;
        here = stack_pos[tos];
        r = here / gmdt_pkg::MAX_SIDE;
        c = here % gmdt_pkg::MAX_SIDE;
        passable = 1'b0;
        nbr = 0;
        // all four tried: backtrack and mark dead end
        if (stack_dir[tos] >= gmdt_pkg::DIR_DONE) begin
          labels[here] = '0;
          labels[here][gmdt_pkg::DEAD_BIT] = 1'b1;
          sp--;
          continue;
        end
        d = stack_dir[tos];
        stack_dir[tos]++;
        case (d)
          gmdt_pkg::DIR_WEST:
            if (c > 0 && !walls[here-1][gmdt_pkg::WALL_EAST]) begin
              passable = 1'b1;
              nbr = here - 1;
            end
          gmdt_pkg::DIR_NORTH:
            if (r > 0 && !walls[here-gmdt_pkg::MAX_SIDE][gmdt_pkg::WALL_SOUTH]) begin
              passable = 1'b1;
              nbr = here - gmdt_pkg::MAX_SIDE;
            end
          gmdt_pkg::DIR_EAST:
            if (c + 1 < cols && !walls[here][gmdt_pkg::WALL_EAST]) begin
              passable = 1'b1;
              nbr = here + 1;
            end
          default:
            if (r + 1 < rows && !walls[here][gmdt_pkg::WALL_SOUTH]) begin
              passable = 1'b1;
              nbr = here + gmdt_pkg::MAX_SIDE;
            end
        endcase
        if (passable && labels[nbr] == 0 && sp < gmdt_pkg::CELLS) begin
          stack_pos[sp] = nbr;
          stack_dir[sp] = int'(gmdt_pkg::DIR_WEST);
          sp++;
          labels[nbr] = gmdt_pkg::LABEL_W'(sp);
          if (nbr == goal) return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Accepted input transfer: update state, queue its result
    function void note_item(bit [gmdt_pkg::IN_DATA_W-1:0] word);
      bit [1:0]     op, wall;
      bit [3:0]     row, col;
      int           pos;
      cell_report_t rep;
      op  = word[1:0];
      row = word[5:2];
      col = word[9:6];
      wall = word[11:10];
      pos = row * gmdt_pkg::MAX_SIDE + col;
      rep.goal_hit = 1'b0;
      rep.mark = gmdt_pkg::MARK_NONE;
      rep.depth = '0;
      case (op)
        gmdt_pkg::OP_LOAD:  walls[pos] = wall;
        gmdt_pkg::OP_SOLVE: rep.goal_hit = trace_maze();
        gmdt_pkg::OP_READ: begin
          if (labels[pos][gmdt_pkg::DEAD_BIT]) begin
            rep.mark = gmdt_pkg::MARK_DEAD;
          end else if (labels[pos] != 0) begin
            rep.mark = gmdt_pkg::MARK_PATH;
            rep.depth = labels[pos][gmdt_pkg::DEPTH_W-1:0];
          end
        end
        default: ;
      endcase
      pending_reports.push_back(rep);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH result %0d: %s", $realtime, result_count, msg);
      fail_count++;
    endtask

    // Accepted result transfer: compare against the oldest expectation
    task check_result(logic [gmdt_pkg::OUT_DATA_W-1:0] data);
      cell_report_t want;
      result_count++;
      if (pending_reports.size() == 0) begin
        report($sformatf("result %h with no item pending", data));
        return;
      end
      want = pending_reports.pop_front();
      if (data[0] !== want.goal_hit)
        report($sformatf("goal_reached got %b want %b", data[0], want.goal_hit));
      if (data[2:1] !== want.mark)
        report($sformatf("cell_mark got %0d want %0d", data[2:1], want.mark));
      if (data[11:3] !== want.depth)
        report($sformatf("path_depth got %0d want %0d", data[11:3], want.depth));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT and stimulus signals
  // --------------------------------------------------------------------------
  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            cfg_we     = 1'b0;
  logic [gmdt_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [gmdt_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  // op[1:0], cell_row[5:2], cell_col[9:6], wall_code[11:10], zero pad
  logic [gmdt_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b1;
  // goal_reached[0], cell_mark[2:1], path_depth[11:3], zero pad
  logic [gmdt_pkg::OUT_DATA_W-1:0] out_tdata;

  maze_scoreboard sb;
  int item_count  = 0;
  int burst_left  = 0;
  int cycle_count = 0;
  int ready_mode  = RX_FREE;
  int ready_left  = 0;

  grid_maze_dfs_tracer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: picks a new random stall pattern whenever its run counter expires
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(RX_FREE, RX_LIGHT);
      ready_left <= $urandom_range(8, 60);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      RX_FREE:   out_tready <= 1'b1;
      RX_JITTER: out_tready <= 1'($urandom_range(0, 1));
      RX_SLOW:   out_tready <= ($urandom_range(0, 7) == 0);
      default:   out_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      sb.check_result(out_tdata);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Random row or column index from zero up to hi
  function automatic logic [3:0] rand_coord(input int hi);
    return 4'($urandom_range(0, hi));
  endfunction

  // Random two-bit wall field
  function automatic logic [1:0] rand_code();
    return 2'($urandom_range(0, 3));
  endfunction

  // One input transfer; bursts of random length separated by random gaps
  task automatic send_item(input logic [1:0] op, input logic [3:0] row, col,
                           input logic [1:0] wall);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 8);
      if ($urandom_range(0, 9) < 2) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(10, 25);
      else gap = $urandom_range(1, 4);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, wall, col, row, op};
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_item({4'b0, wall, col, row, op});
    item_count++;
  endtask

  // Hold the sender until every expected result is back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input gmdt_pkg::reg_idx_t idx,
                           input logic [gmdt_pkg::CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic set_maze_regs(input logic [4:0] rows, cols,
                               input logic [3:0] sr, sc, gr, gc);
    write_reg(gmdt_pkg::REG_ROW_COUNT, rows);
    write_reg(gmdt_pkg::REG_COL_COUNT, cols);
    write_reg(gmdt_pkg::REG_START_ROW, gmdt_pkg::CFG_DATA_W'(sr));
    write_reg(gmdt_pkg::REG_START_COL, gmdt_pkg::CFG_DATA_W'(sc));
    write_reg(gmdt_pkg::REG_GOAL_ROW,  gmdt_pkg::CFG_DATA_W'(gr));
    write_reg(gmdt_pkg::REG_GOAL_COL,  gmdt_pkg::CFG_DATA_W'(gc));
    cfg_we <= 1'b0;
  endtask

  // Open cells most often, so that searches run deep
  function automatic logic [1:0] random_walls();
    int k;
    k = $urandom_range(0, 9);
    if (k < 4) return CODE_OPEN;
    if (k < 6) return CODE_EAST;
    if (k < 8) return CODE_SOUTH;
    return CODE_BOTH;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [4:0] rows_set, cols_set;
    logic [3:0] sr, sc, gr, gc;
    int         rows, cols, k;
    bit         fresh;

    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: a single cell that is both start and goal
    send_item(gmdt_pkg::OP_READ,  4'd0,  4'd0,  CODE_BOTH);
    send_item(gmdt_pkg::OP_SOLVE, 4'd15, 4'd15, CODE_OPEN);
    send_item(gmdt_pkg::OP_READ,  4'd0,  4'd0,  CODE_OPEN);
    send_item(gmdt_pkg::OP_READ,  4'd15, 4'd15, CODE_EAST);
    send_item(OP_SPARE,           4'd15, 4'd15, CODE_BOTH);
    send_item(gmdt_pkg::OP_LOAD,  4'd15, 4'd15, CODE_BOTH);
    send_item(gmdt_pkg::OP_LOAD,  4'd0,  4'd0,  CODE_OPEN);
    wait_idle();

    // zero rows clamps to one, 31 columns to sixteen: corridor walked west
    set_maze_regs(5'd0, 5'd31, 4'd0, 4'd15, 4'd0, 4'd0);
    send_item(gmdt_pkg::OP_SOLVE, 4'd7, 4'd8, CODE_SOUTH);
    send_item(gmdt_pkg::OP_READ,  4'd0, 4'd0, CODE_OPEN);
    send_item(gmdt_pkg::OP_READ,  4'd0, 4'd8, CODE_OPEN);
    wait_idle();

    // 31 rows, zero columns: corridor walked north up column zero
    set_maze_regs(5'd31, 5'd0, 4'd15, 4'd0, 4'd0, 4'd0);
    send_item(gmdt_pkg::OP_SOLVE, 4'd0, 4'd0, CODE_OPEN);
    send_item(gmdt_pkg::OP_READ,  4'd0, 4'd0, CODE_OPEN);
    wait_idle();

    // start outside the used area: labels cleared, nothing reached
    set_maze_regs(5'd2, 5'd2, 4'd15, 4'd0, 4'd1, 4'd1);
    send_item(gmdt_pkg::OP_SOLVE, 4'd0, 4'd0, CODE_OPEN);
    send_item(gmdt_pkg::OP_READ,  4'd0, 4'd0, CODE_OPEN);
    wait_idle();

    // goal outside the used area: every reachable cell ends as a dead end
    set_maze_regs(5'd2, 5'd2, 4'd0, 4'd0, 4'd15, 4'd15);
    send_item(gmdt_pkg::OP_SOLVE, 4'd0, 4'd0, CODE_OPEN);
    send_item(gmdt_pkg::OP_READ,  4'd0, 4'd0, CODE_OPEN);
    send_item(gmdt_pkg::OP_READ,  4'd1, 4'd1, CODE_OPEN);
    wait_idle();

    // full grid serpentine: every cell on the path, goal at depth 256
    set_maze_regs(5'd16, 5'd16, 4'd0, 4'd0, 4'd15, 4'd0);
    for (int r = 0; r < gmdt_pkg::MAX_SIDE; r++) begin
      for (int c = 0; c < gmdt_pkg::MAX_SIDE; c++) begin
        if ((r % 2 == 0) ? (c == gmdt_pkg::MAX_SIDE - 1) : (c == 0))
          send_item(gmdt_pkg::OP_LOAD, 4'(r), 4'(c), CODE_OPEN);
        else
          send_item(gmdt_pkg::OP_LOAD, 4'(r), 4'(c), CODE_SOUTH);
      end
    end
    send_item(gmdt_pkg::OP_SOLVE, 4'd3, 4'd12, CODE_BOTH);
    send_item(gmdt_pkg::OP_READ, 4'd15, 4'd0,  CODE_OPEN);
    send_item(gmdt_pkg::OP_READ, 4'd15, 4'd15, CODE_OPEN);
    send_item(gmdt_pkg::OP_READ, 4'd0,  4'd0,  CODE_OPEN);
    repeat (5) send_item(gmdt_pkg::OP_READ, rand_coord(15), rand_coord(15), rand_code());

    // random mazes: mostly small, sometimes reusing walls with a new start/goal
    fresh = 1'b1;
    rows_set = 5'd1;
    cols_set = 5'd1;
    while (item_count < ITEM_TARGET) begin
      if (fresh) begin
        rows_set = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(1, 5));
        cols_set = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(1, 5));
      end
      rows = sb.effective_side(rows_set);
      cols = sb.effective_side(cols_set);
      sr = ($urandom_range(0, 9) == 0) ? rand_coord(15) : rand_coord(rows - 1);
      sc = ($urandom_range(0, 9) == 0) ? rand_coord(15) : rand_coord(cols - 1);
      gr = ($urandom_range(0, 7) == 0) ? rand_coord(15) : rand_coord(rows - 1);
      gc = ($urandom_range(0, 7) == 0) ? rand_coord(15) : rand_coord(cols - 1);
      wait_idle();
      set_maze_regs(rows_set, cols_set, sr, sc, gr, gc);

      if (fresh) begin
        if (rows * cols <= 36) begin
          for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
              send_item(gmdt_pkg::OP_LOAD, 4'(r), 4'(c), random_walls());
        end else begin
          repeat (12) send_item(gmdt_pkg::OP_LOAD, rand_coord(rows - 1),
                                rand_coord(cols - 1), random_walls());
        end
        // stray loads anywhere in the store
        repeat ($urandom_range(0, 2))
          send_item(gmdt_pkg::OP_LOAD, rand_coord(15), rand_coord(15), rand_code());
      end

      send_item(gmdt_pkg::OP_SOLVE, rand_coord(15), rand_coord(15), rand_code());
      repeat ($urandom_range(4, 9)) begin
        k = $urandom_range(0, 19);
        if (k == 0)
          send_item(OP_SPARE, rand_coord(15), rand_coord(15), rand_code());
        else if (k == 1)
          send_item(gmdt_pkg::OP_SOLVE, rand_coord(15), rand_coord(15), rand_code());
        else if (k == 2)
          send_item(gmdt_pkg::OP_READ, rand_coord(15), rand_coord(15), rand_code());
        else
          send_item(gmdt_pkg::OP_READ, rand_coord(rows - 1), rand_coord(cols - 1),
                    rand_code());
      end
      fresh = ($urandom_range(0, 1) == 0);
    end

    // drain and allow for any stray result
    wait_idle();
    repeat (50) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/gmdt_pkg.sv
sv/grid_maze_dfs_tracer.sv
test/tb.sv
